/* rtl/ilir_pkg.sv */
// package for the indexed list unit: action and status codes, field widths,
// and the command / status bundles between controller and datapath
// no dependencies

package ilir_pkg;

  // default list capacity
  localparam int DEPTH_DEF = 16;

  // field widths
  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // packed stream widths
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic exec;      // set up cursor, issue read for get
    logic shift_rd;  // read the neighbor entry of the cursor
    logic shift_wr;  // write it at the cursor and step the cursor
    logic finish;    // final write, count update, load result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic shifting;  // accepted remove or insert
    logic more;      // another entry still to be moved
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

/* rtl/indexed_list_insert_remove_unit.sv */
// Indexed list unit: an ordered list of up to DEPTH signed 32-bit words held
// in a single-port-write, registered-read memory. A request is taken in the
// idle state and its result goes to an output register, so a new request is
// taken while the previous result still waits. With the result side free,
// set, append, get and rejected requests pass through the execute and finish
// states before the next acceptance. Remove and insert move entries one at a
// time through the memory's one read and one write port, with a read state and
// a write state per moved entry and one more read state to see that no entry is
// left: remove at index p moves count-1-p entries, insert at p moves count-p.
// The list is empty after reset; no clearing pass is needed.
// depends on ilir_pkg, ilir_ctrl, ilir_dp

module indexed_list_insert_remove_unit import ilir_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // action[2:0], position[7:3], word_in[39:8]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // read_word[31:0], status[33:32],
                                      // entry_count[38:34], zero[39]
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ilir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  ilir_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* rtl/ilir_ctrl.sv */
// controller state machine of the indexed list unit
// depends on ilir_pkg (cmd_t, stat_t)

module ilir_ctrl import ilir_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SHRD = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.shifting ? S_SHRD : S_FIN;
      end
      S_SHRD: begin
        if (stat.more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHWR;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHRD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/ilir_dp.sv */
// datapath of the indexed list unit: request register, entry memory,
// entry count, move cursor and result register
// depends on ilir_pkg (codes, widths, cmd_t, stat_t)

module ilir_dp import ilir_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  cmd_t             cmd,
  output stat_t            stat
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // request register
  logic [ACT_W-1:0]  req_act;
  logic [POS_W-1:0]  req_pos;
  logic [WORD_W-1:0] req_word;

  // list state
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cursor;

  // result register
  logic [WORD_W-1:0] out_word;
  logic [STAT_W-1:0] out_stat;
  logic [CNT_W-1:0]  out_cnt;

  logic              is_set, is_append, is_get, is_remove, is_insert;
  logic [CMPW-1:0]   pos_x, count_x, cursor_x, count_after_x;
  logic              range_err, full_err, ok;
  logic [CW-1:0]     cur_up, cur_dn, count_after;
  logic              re, we;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [STAT_W-1:0] stat_code;
  logic [WORD_W-1:0] result_word;

  // decode
  assign is_set    = (req_act == ACT_SET);
  assign is_append = (req_act == ACT_APPEND);
  assign is_get    = (req_act == ACT_GET);
  assign is_remove = (req_act == ACT_REMOVE);
  assign is_insert = (req_act == ACT_INSERT);

  assign pos_x    = CMPW'(req_pos);
  assign count_x  = CMPW'(count);
  assign cursor_x = CMPW'(cursor);

  // range and full checks, range wins
  assign range_err = ((is_set || is_get || is_remove) && (pos_x >= count_x)) ||
                     (is_insert && (pos_x > count_x));
  assign full_err  = !range_err && (is_append || is_insert) &&
                     (count_x == CMPW'(DEPTH));
  assign ok        = !range_err && !full_err;

  assign stat_code = range_err ? ST_RANGE : (full_err ? ST_FULL : ST_OK);

  // cursor neighbors
  assign cur_up = cursor + CW'(1);
  assign cur_dn = cursor - CW'(1);

  assign stat.shifting = ok && (is_remove || is_insert);
  assign stat.more     = is_remove ? ((cursor_x + CMPW'(1)) < count_x)
                                   : (cursor_x > pos_x);
  assign stat.out_free = !m_tvalid || m_tready;

  // memory port selection
  assign re      = cmd.exec || cmd.shift_rd;
  assign rd_addr = cmd.exec  ? pos_x[AW-1:0] :
                   is_remove ? cur_up[AW-1:0] : cur_dn[AW-1:0];
  assign we      = cmd.shift_wr ||
                   (cmd.finish && ok && (is_set || is_append || is_insert));
  assign wr_addr = cmd.shift_wr ? cursor[AW-1:0] :
                   is_append    ? count[AW-1:0] : pos_x[AW-1:0];
  assign wr_data = cmd.shift_wr ? rdata : req_word;

  // count after the request
  always_comb begin
    count_after = count;
    if (ok && (is_append || is_insert)) begin
      count_after = count + CW'(1);
    end else if (ok && is_remove) begin
      count_after = count - CW'(1);
    end
  end
  assign count_after_x = CMPW'(count_after);

  // result word
  always_comb begin
    if (!ok) begin
      result_word = '1;
    end else if (is_get) begin
      result_word = rdata;
    end else begin
      result_word = '0;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rdata <= mem[rd_addr];
    end
  end

  // request capture and cursor
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_act  <= s_tdata[2:0];
      req_pos  <= s_tdata[7:3];
      req_word <= s_tdata[39:8];
    end
    if (cmd.exec) begin
      cursor <= is_remove ? pos_x[CW-1:0] : count;
    end else if (cmd.shift_wr) begin
      cursor <= is_remove ? cur_up : cur_dn;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_after;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word <= result_word;
      out_stat <= stat_code;
      out_cnt  <= count_after_x[CNT_W-1:0];
    end
  end

  assign m_tdata = {1'b0, out_cnt, out_stat, out_word};

endmodule

/* rtl/ilir_chk.sv */
// port-level checker for the indexed list unit, with its bind statement
// depends on ilir_pkg (widths, status codes)

module ilir_chk import ilir_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [WORD_W-1:0] read_word;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entry_count;

  assign read_word   = m_tdata[31:0];
  assign status      = m_tdata[33:32];
  assign entry_count = m_tdata[38:34];

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // rejected request reads all ones
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status != ST_OK) |-> (read_word == '1))
    else $error("error result without all-ones word");

  // full status only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_FULL) |-> (entry_count == CNT_W'(DEPTH)))
    else $error("full status with list not full");

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH > 31) || (int'(entry_count) <= DEPTH))
    else $error("entry count above capacity");

endmodule

bind indexed_list_insert_remove_unit ilir_chk #(
  .DEPTH (DEPTH)
) u_ilir_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* bench/tb.sv */
// testbench for indexed_list_insert_remove_unit: directed and random list requests
// with a scoreboard kept against an in-bench copy of the list
// depends on ilir_pkg and the rtl of the unit
`timescale 1ns / 100ps

module tb;
  import ilir_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int ACT_CODES = 1 << ACT_W;
  localparam int TAIL_WAIT = 3 + 2 * DEPTH + 8;

  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;

  typedef enum int {GROW, SHRINK, MIXED} drift_e;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;   // action[2:0], position[7:3], word_in[39:8]
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;       // read_word[31:0], status[33:32], entry_count[38:34]

  // shadow copy of the list
  logic [WORD_W-1:0] list_mem [DEPTH];
  int                list_len = 0;

  list_result_t pending_results[$];
  int           mismatches = 0;
  bit           sender_gaps = 1'b1;
  bit           sink_stalls = 1'b1;
  int           sink_hold = 0;

  indexed_list_insert_remove_unit #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow list and return what the unit should answer
  function automatic list_result_t list_outcome(input logic [ACT_W-1:0] act,
                                                input logic [POS_W-1:0] pos,
                                                input logic [WORD_W-1:0] word);
    list_result_t r;
    int i;
    r.read_word = '0;
    r.status    = ST_OK;
    case (act)
      ACT_SET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else list_mem[pos] = word;
      end
      ACT_APPEND: begin
        if (list_len >= DEPTH) r.status = ST_FULL;
        else begin
          list_mem[list_len] = word;
          list_len++;
        end
      end
      ACT_GET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.read_word = list_mem[pos];
      end
      ACT_REMOVE: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      ACT_INSERT: begin
        // range check wins over the full check
        if (pos > list_len) r.status = ST_RANGE;
        else if (list_len >= DEPTH) r.status = ST_FULL;
        else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos] = word;
          list_len++;
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) r.read_word = '1;
    r.count = list_len[CNT_W-1:0];
    return r;
  endfunction

  // random word, with the sign extremes, zero and all ones mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one request; valid stays high after acceptance so back-to-back requests
  // never lower and raise it in the same step
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {word, pos, act};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(list_outcome(act, pos, word));
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result sink: per-result stall, plus a long hold when a test asks for one
  initial begin : result_sink
    int wait_cycles;
    do @(posedge clk); while (rst);
    forever begin
      wait_cycles = sink_stalls ? $urandom_range(0, 19) : 0;
      wait_cycles += sink_hold;
      sink_hold = 0;
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    list_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.read_word = m_tdata[WORD_W-1:0];
      got.status    = m_tdata[WORD_W +: STAT_W];
      got.count     = m_tdata[WORD_W+STAT_W +: CNT_W];
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: read_word %h status %0d entry_count %0d",
               got.read_word, got.status, got.count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_word !== want.read_word) begin
          $error("read_word: expected %h, actual %h", want.read_word, got.read_word);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  // requests against the empty list, and the unused action codes
  task automatic test_empty_list();
    int a;
    send_request(ACT_GET, '1, pick_word());
    send_request(ACT_SET, '0, WORD_MAX);
    send_request(ACT_REMOVE, '0, pick_word());
    send_request(ACT_INSERT, POS_W'(1), WORD_MIN);
    for (a = int'(ACT_INSERT) + 1; a < ACT_CODES; a++)
      send_request(ACT_W'(a), POS_W'($urandom), pick_word());
  endtask

  // fill to capacity, then hit the full and boundary cases
  task automatic test_capacity();
    send_request(ACT_INSERT, '0, WORD_MIN);
    send_request(ACT_APPEND, POS_W'($urandom), WORD_MAX);
    while (list_len < DEPTH) begin
      if (list_len % 2 == 1) send_request(ACT_APPEND, POS_W'($urandom), pick_word());
      else send_request(ACT_INSERT, POS_W'($urandom_range(0, list_len)), pick_word());
    end
    send_request(ACT_APPEND, '0, pick_word());
    send_request(ACT_INSERT, POS_W'(DEPTH), pick_word());
    send_request(ACT_INSERT, POS_W'(DEPTH + 1), pick_word());
    send_request(ACT_GET, '0, '0);
    send_request(ACT_GET, POS_W'(DEPTH - 1), '0);
    send_request(ACT_GET, POS_W'(DEPTH), '0);
    send_request(ACT_SET, POS_W'(DEPTH - 1), '1);
    send_request(ACT_REMOVE, POS_W'(DEPTH - 1), '0);
    send_request(ACT_REMOVE, '0, '0);
    send_request(ACT_INSERT, POS_W'(list_len), pick_word());
  endtask

  // long hold on the result side while requests keep coming
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    sink_hold   = 400;
    repeat (40)
      send_request(ACT_W'($urandom_range(0, int'(ACT_INSERT))),
                   POS_W'($urandom_range(0, list_len)), pick_word());
    sender_gaps = 1'b1;
  endtask

  // random batches that drift the fill level up and down
  task automatic test_random_ops(input int n_items);
    int done;
    int batch;
    int r;
    int add_w;
    int rem_w;
    drift_e drift;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    done = 0;
    while (done < n_items) begin
      batch = $urandom_range(20, 120);
      // last batch stops at the requested total
      if (batch > n_items - done) batch = n_items - done;
      drift = drift_e'($urandom_range(0, 2));
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      case (drift)
        GROW:    begin add_w = 55; rem_w = 10; end
        SHRINK:  begin add_w = 15; rem_w = 50; end
        default: begin add_w = 30; rem_w = 30; end
      endcase
      repeat (batch) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          act = ACT_W'(int'(ACT_INSERT) + 1 +
                       $urandom_range(0, ACT_CODES - 2 - int'(ACT_INSERT)));
        else if (r < 4 + add_w)
          act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
        else if (r < 4 + add_w + rem_w)
          act = ACT_REMOVE;
        else
          act = $urandom_range(0, 1) ? ACT_GET : ACT_SET;
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom);
        else pos = POS_W'($urandom_range(0, list_len));
        send_request(act, pos, pick_word());
        done++;
      end
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin : main_seq
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_capacity();
    drain_results();
    test_backpressure();
    drain_results();
    test_random_ops(1180);
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("** indexed_list_insert_remove_unit: PASSED **");
    else
      $display("** indexed_list_insert_remove_unit: FAILED **");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("** indexed_list_insert_remove_unit: FAILED **");
    $finish;
  end

endmodule
